>>> sv/bcu1sfe_pkg.sv
// Shared types and codes of the serial frame exchange unit.
package bcu1sfe_pkg;

  localparam logic [1:0] ModeQueue = 2'd0;
  localparam logic [1:0] ModePoll  = 2'd1;
  localparam logic [1:0] ModeDone  = 2'd2;

  localparam logic [2:0] KindOk   = 3'd0;
  localparam logic [2:0] KindXchg = 3'd1;
  localparam logic [2:0] KindRxb  = 3'd2;
  localparam logic [2:0] KindSent = 3'd3;
  localparam logic [2:0] KindErr  = 3'd4;
  localparam logic [2:0] KindIdle = 3'd5;

  localparam logic [1:0] FailNone  = 2'd0;
  localparam logic [2:0] ErrNoAck  = 3'd4;

  localparam logic [7:0] ByteIdle  = 8'hff;
  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [7:0] HdrFlag   = 8'h20;
  localparam int unsigned LenW     = 5;

  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [1:0] fail;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       rx_frame_end;
    logic [2:0] error_code;
    logic       dropped;
    logic       last_result;
  } out_t;

  typedef struct packed {
    out_t res;
    logic two;
  } qent_t;

endpackage

>>> sv/bcu1sfe_front.sv
// Front part: accepts items, updates the link state and frame buffer, builds results.
module bcu1sfe_front #(
  parameter int unsigned MAX_FRAME = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bcu1sfe_pkg::in_t    in_item_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output bcu1sfe_pkg::qent_t  ent_o
);

  localparam int unsigned IdxW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam logic [bcu1sfe_pkg::LenW-1:0] MaxLen = bcu1sfe_pkg::LenW'(MAX_FRAME);

  typedef enum logic [1:0] {PhIdle, PhHeader, PhSend, PhRecv} phase_e;

  logic [7:0] store_q [MAX_FRAME];

  phase_e                         phase_q, phase_d;
  logic [bcu1sfe_pkg::LenW-1:0]   len_q, len_d;
  logic                           pend_q, pend_d;
  logic [7:0]                     hdr_q, hdr_d;
  logic [bcu1sfe_pkg::LenW-1:0]   pos_q, pos_d;
  logic [bcu1sfe_pkg::LenW-1:0]   rem_q, rem_d;
  logic                           accept;
  logic                           wr_en;
  logic [bcu1sfe_pkg::LenW-1:0]   pos_n;
  logic [bcu1sfe_pkg::LenW-1:0]   rem_n;
  logic [7:0]                     hdr;
  bcu1sfe_pkg::out_t              res;
  logic                           two;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign pos_n      = bcu1sfe_pkg::LenW'(pos_q + 1'b1);
  assign rem_n      = bcu1sfe_pkg::LenW'(rem_q - 1'b1);

  always_comb begin
    hdr      = {1'b0, bcu1sfe_pkg::HdrFlag[6:0] | {2'b00, len_q}};
    hdr[7]   = ^hdr[6:0];
    phase_d  = phase_q;
    len_d    = len_q;
    pend_d   = pend_q;
    hdr_d    = hdr_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    wr_en    = 1'b0;
    two      = 1'b0;
    res      = '0;
    res.kind = bcu1sfe_pkg::KindOk;
    unique case (in_item_i.mode)
      bcu1sfe_pkg::ModeQueue: begin
        if (pend_q) begin
          res.dropped = 1'b1;
        end else begin
          if (len_q < MaxLen) begin
            wr_en = 1'b1;
            len_d = bcu1sfe_pkg::LenW'(len_q + 1'b1);
          end else begin
            res.dropped = 1'b1;
          end
          if (in_item_i.frame_end && (len_d != '0)) begin
            pend_d = 1'b1;
          end
        end
      end
      bcu1sfe_pkg::ModePoll: begin
        if (phase_q == PhIdle) begin
          hdr_d       = pend_q ? hdr : bcu1sfe_pkg::ByteIdle;
          phase_d     = PhHeader;
          res.kind    = bcu1sfe_pkg::KindXchg;
          res.tx_byte = hdr_d;
        end
      end
      bcu1sfe_pkg::ModeDone: begin
        if (phase_q != PhIdle) begin
          if (in_item_i.fail != bcu1sfe_pkg::FailNone) begin
            phase_d        = PhIdle;
            res.kind       = bcu1sfe_pkg::KindErr;
            res.error_code = {1'b0, in_item_i.fail};
          end else begin
            unique case (phase_q)
              PhHeader: begin
                if (in_item_i.data_byte == bcu1sfe_pkg::ByteIdle &&
                    hdr_q != bcu1sfe_pkg::ByteIdle) begin
                  pos_d = '0;
                  if (len_q != '0 && len_q <= MaxLen) begin
                    phase_d     = PhSend;
                    res.kind    = bcu1sfe_pkg::KindXchg;
                    res.tx_byte = store_q[0];
                  end else begin
                    phase_d        = PhIdle;
                    res.kind       = bcu1sfe_pkg::KindErr;
                    res.error_code = bcu1sfe_pkg::ErrNoAck;
                  end
                end else if (in_item_i.data_byte == bcu1sfe_pkg::ByteIdle) begin
                  phase_d  = PhIdle;
                  res.kind = bcu1sfe_pkg::KindIdle;
                end else begin
                  rem_d = in_item_i.data_byte[bcu1sfe_pkg::LenW-1:0];
                  if (rem_d == '0) begin
                    phase_d          = PhIdle;
                    res.kind         = bcu1sfe_pkg::KindRxb;
                    res.rx_frame_end = 1'b1;
                  end else begin
                    phase_d     = PhRecv;
                    res.kind    = bcu1sfe_pkg::KindXchg;
                    res.tx_byte = bcu1sfe_pkg::ByteZero;
                  end
                end
              end
              PhSend: begin
                pos_d = pos_n;
                if (pos_n < len_q && pos_n < MaxLen) begin
                  res.kind    = bcu1sfe_pkg::KindXchg;
                  res.tx_byte = store_q[pos_n[IdxW-1:0]];
                end else begin
                  phase_d = PhIdle;
                  if (in_item_i.data_byte == bcu1sfe_pkg::ByteZero) begin
                    pend_d   = 1'b0;
                    len_d    = '0;
                    res.kind = bcu1sfe_pkg::KindSent;
                  end else begin
                    res.kind       = bcu1sfe_pkg::KindErr;
                    res.error_code = bcu1sfe_pkg::ErrNoAck;
                  end
                end
              end
              PhRecv: begin
                rem_d       = rem_n;
                res.kind    = bcu1sfe_pkg::KindRxb;
                res.rx_byte = in_item_i.data_byte;
                if (rem_n == '0) begin
                  phase_d          = PhIdle;
                  res.rx_frame_end = 1'b1;
                end else begin
                  two = 1'b1;
                end
              end
              PhIdle: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    res.last_result = !two;
    ent_o.res       = res;
    ent_o.two       = two;
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      store_q[len_q[IdxW-1:0]] <= in_item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      len_q   <= '0;
      pend_q  <= 1'b0;
      hdr_q   <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      hdr_q   <= hdr_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen) else $error("frame length beyond buffer");
  a_send_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSend) |-> pend_q) else $error("send without pending frame");
  a_recv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRecv) |-> (rem_q != '0)) else $error("receive with no bytes left");

endmodule

>>> sv/bcu1sfe_queue.sv
// Short result queue between the front and back parts.
module bcu1sfe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bcu1sfe_pkg::qent_t  ent_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output bcu1sfe_pkg::qent_t  head_o
);

  bcu1sfe_pkg::qent_t              mem_q [bcu1sfe_pkg::QDepth];
  logic [bcu1sfe_pkg::QPtrW-1:0]   wptr_q, rptr_q;
  logic [bcu1sfe_pkg::QCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == bcu1sfe_pkg::QCntW'(bcu1sfe_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= bcu1sfe_pkg::QCntW'(cnt_q + push_i - pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bcu1sfe_pkg::QCntW'(bcu1sfe_pkg::QDepth)) else $error("queue count too large");

endmodule

>>> sv/bcu1sfe_back.sv
// Back part: delivers queued results, expanding an entry into its follow-up request.
module bcu1sfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  bcu1sfe_pkg::qent_t  head_i,
  input  logic                out_stall_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output bcu1sfe_pkg::out_t   out_item_o
);

  logic              sel_q;
  logic              take;
  bcu1sfe_pkg::out_t follow;

  always_comb begin
    follow             = '0;
    follow.kind        = bcu1sfe_pkg::KindXchg;
    follow.tx_byte     = bcu1sfe_pkg::ByteZero;
    follow.last_result = 1'b1;
  end

  assign out_valid_o = !empty_i;
  assign out_item_o  = sel_q ? follow : head_i.res;
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && (sel_q || !head_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= head_i.two && !sel_q;
    end
  end

endmodule

>>> sv/bcu1_serial_frame_exchange_unit.sv
// Top level of the serial frame exchange unit: front, result queue and back.
// The first result of an item is written into the queue when accepted and offered from its head.
// Throughput: one item per cycle while the queue has room; two results of an item leave in turn.
// The two-entry queue sets the input stall; the back delivers one result a cycle unless stalled.
// Reset clears the link state, frame length, pending flag and queue; the frame buffer is not cleared.
module bcu1_serial_frame_exchange_unit #(
  parameter int unsigned MAX_FRAME = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bcu1sfe_pkg::in_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bcu1sfe_pkg::out_t  out_item_o
);

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  bcu1sfe_pkg::qent_t ent;
  bcu1sfe_pkg::qent_t head;

  bcu1sfe_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .ent_o      (ent)
  );

  bcu1sfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  bcu1sfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .out_stall_i (out_stall_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> test/bcu1_serial_frame_exchange_unit_tb.sv
// Self-checking testbench of the serial frame exchange unit: directed link cycles, then random traffic.
`timescale 1ns / 1ps

module bcu1_serial_frame_exchange_unit_tb;

  localparam int unsigned MaxFrame = 31;
  localparam logic [4:0] MaxLen        = 5'(MaxFrame);
  localparam logic [1:0] ModeSpare     = 2'd3;
  localparam logic [1:0] FailStartSync = 2'd1;
  localparam logic [1:0] FailEndSync   = 2'd2;
  localparam logic [1:0] FailNoReply   = 2'd3;
  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [7:0] HdrParity     = 8'h80;
  localparam int unsigned TargetItems  = 1350;

  typedef enum logic [1:0] {LinkIdle, LinkHeader, LinkSend, LinkRecv} link_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bcu1sfe_pkg::in_t  in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bcu1sfe_pkg::out_t out_item_o;

  // Predicted link state
  logic [7:0]  frame_bytes [MaxFrame];
  logic [4:0]  frame_len = '0;
  logic        frame_pending = 1'b0;
  link_phase_e link_phase = LinkIdle;
  logic [7:0]  header_byte = '0;
  logic [4:0]  byte_pos = '0;
  logic [4:0]  recv_left = '0;

  bcu1sfe_pkg::out_t awaited_results [$];
  int   mismatches = 0;
  int   items_accepted = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   stall_cycle = 0;
  int   stall_style = 0;

  bcu1_serial_frame_exchange_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bcu1sfe_pkg::in_t link_item(logic [1:0] mode, logic [7:0] db,
                                                 logic fend, logic [1:0] fail);
    bcu1sfe_pkg::in_t it;
    it.mode = mode;
    it.data_byte = db;
    it.frame_end = fend;
    it.fail = fail;
    return it;
  endfunction

  function automatic bcu1sfe_pkg::out_t result_of(logic [2:0] kind, logic [7:0] tx,
                                                  logic [7:0] rx, logic fend,
                                                  logic [2:0] err, logic drop);
    bcu1sfe_pkg::out_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.rx_byte = rx;
    r.rx_frame_end = fend;
    r.error_code = err;
    r.dropped = drop;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic void predict_exchange(bcu1sfe_pkg::in_t it);
    bcu1sfe_pkg::out_t first;
    bcu1sfe_pkg::out_t second;
    logic two;
    logic [7:0] hdr;
    first = result_of(bcu1sfe_pkg::KindOk, bcu1sfe_pkg::ByteZero, bcu1sfe_pkg::ByteZero,
                      1'b0, ErrNone, 1'b0);
    second = first;
    two = 1'b0;
    unique case (it.mode)
      bcu1sfe_pkg::ModeQueue: begin
        if (frame_pending) begin
          first.dropped = 1'b1;
        end else begin
          if (frame_len < MaxLen) begin
            frame_bytes[frame_len] = it.data_byte;
            frame_len = frame_len + 5'd1;
          end else begin
            first.dropped = 1'b1;
          end
          if (it.frame_end && frame_len != 0) frame_pending = 1'b1;
        end
      end
      bcu1sfe_pkg::ModePoll: begin
        if (link_phase == LinkIdle) begin
          if (frame_pending) begin
            hdr = {3'b000, frame_len} | bcu1sfe_pkg::HdrFlag;
            if (^hdr) hdr = hdr | HdrParity;
          end else begin
            hdr = bcu1sfe_pkg::ByteIdle;
          end
          header_byte = hdr;
          link_phase = LinkHeader;
          first = result_of(bcu1sfe_pkg::KindXchg, hdr, bcu1sfe_pkg::ByteZero, 1'b0,
                            ErrNone, 1'b0);
        end
      end
      bcu1sfe_pkg::ModeDone: begin
        if (link_phase != LinkIdle) begin
          if (it.fail != bcu1sfe_pkg::FailNone) begin
            link_phase = LinkIdle;
            first = result_of(bcu1sfe_pkg::KindErr, bcu1sfe_pkg::ByteZero,
                              bcu1sfe_pkg::ByteZero, 1'b0, {1'b0, it.fail}, 1'b0);
          end else begin
            unique case (link_phase)
              LinkHeader: begin
                if (it.data_byte == bcu1sfe_pkg::ByteIdle &&
                    header_byte != bcu1sfe_pkg::ByteIdle) begin
                  byte_pos = '0;
                  if (frame_len != 0) begin
                    link_phase = LinkSend;
                    first = result_of(bcu1sfe_pkg::KindXchg, frame_bytes[0],
                                      bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                  end else begin
                    link_phase = LinkIdle;
                    first = result_of(bcu1sfe_pkg::KindErr, bcu1sfe_pkg::ByteZero,
                                      bcu1sfe_pkg::ByteZero, 1'b0, bcu1sfe_pkg::ErrNoAck,
                                      1'b0);
                  end
                end else if (it.data_byte == bcu1sfe_pkg::ByteIdle) begin
                  link_phase = LinkIdle;
                  first = result_of(bcu1sfe_pkg::KindIdle, bcu1sfe_pkg::ByteZero,
                                    bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                end else begin
                  recv_left = it.data_byte[4:0];
                  if (recv_left == 0) begin
                    link_phase = LinkIdle;
                    first = result_of(bcu1sfe_pkg::KindRxb, bcu1sfe_pkg::ByteZero,
                                      bcu1sfe_pkg::ByteZero, 1'b1, ErrNone, 1'b0);
                  end else begin
                    link_phase = LinkRecv;
                    first = result_of(bcu1sfe_pkg::KindXchg, bcu1sfe_pkg::ByteZero,
                                      bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                  end
                end
              end
              LinkSend: begin
                byte_pos = byte_pos + 5'd1;
                if (byte_pos < frame_len && byte_pos < MaxLen) begin
                  first = result_of(bcu1sfe_pkg::KindXchg, frame_bytes[byte_pos],
                                    bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                end else begin
                  link_phase = LinkIdle;
                  if (it.data_byte == bcu1sfe_pkg::ByteZero) begin
                    frame_pending = 1'b0;
                    frame_len = '0;
                    first = result_of(bcu1sfe_pkg::KindSent, bcu1sfe_pkg::ByteZero,
                                      bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                  end else begin
                    first = result_of(bcu1sfe_pkg::KindErr, bcu1sfe_pkg::ByteZero,
                                      bcu1sfe_pkg::ByteZero, 1'b0, bcu1sfe_pkg::ErrNoAck,
                                      1'b0);
                  end
                end
              end
              default: begin
                recv_left = recv_left - 5'd1;
                if (recv_left == 0) begin
                  link_phase = LinkIdle;
                  first = result_of(bcu1sfe_pkg::KindRxb, bcu1sfe_pkg::ByteZero,
                                    it.data_byte, 1'b1, ErrNone, 1'b0);
                end else begin
                  first = result_of(bcu1sfe_pkg::KindRxb, bcu1sfe_pkg::ByteZero,
                                    it.data_byte, 1'b0, ErrNone, 1'b0);
                  second = result_of(bcu1sfe_pkg::KindXchg, bcu1sfe_pkg::ByteZero,
                                     bcu1sfe_pkg::ByteZero, 1'b0, ErrNone, 1'b0);
                  two = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    first.last_result = !two;
    awaited_results.push_back(first);
    if (two) begin
      second.last_result = 1'b1;
      awaited_results.push_back(second);
    end
  endfunction

  task automatic drive_item(input bcu1sfe_pkg::in_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_exchange(it);
    items_accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic queue_frame(input int len, input int extra);
    int i;
    for (i = 0; i < len + extra; i++) begin
      drive_item(link_item(bcu1sfe_pkg::ModeQueue, 8'($urandom_range(0, 255)),
                           i == len + extra - 1, 2'($urandom_range(0, 3))));
    end
  endtask

  task automatic answer_frame_bytes(input bit clean);
    logic [7:0] reply;
    logic [1:0] fail_code;
    bit last_byte;
    while (link_phase == LinkSend) begin
      last_byte = (int'(byte_pos) + 1 >= int'(frame_len));
      fail_code = bcu1sfe_pkg::FailNone;
      if (!clean && $urandom_range(0, 24) == 0) fail_code = 2'($urandom_range(1, 3));
      if (last_byte) begin
        reply = (clean || $urandom_range(0, 3) != 0) ? bcu1sfe_pkg::ByteZero :
                8'($urandom_range(1, 255));
      end else begin
        reply = 8'($urandom_range(0, 255));
      end
      drive_item(link_item(bcu1sfe_pkg::ModeDone, reply, 1'($urandom_range(0, 1)),
                           fail_code));
    end
  endtask

  task automatic test_idle_link();
    gaps_on = 1'b1;
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(ModeSpare, bcu1sfe_pkg::ByteIdle, 1'b1, FailNoReply));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
  endtask

  task automatic test_receive_paths();
    gaps_on = 1'b1;
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h20, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h02, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'hab, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h55, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h03, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h11, 1'b0, FailStartSync));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0, FailNoReply));
  endtask

  task automatic test_send_paths();
    gaps_on = 1'b1;
    drive_item(link_item(bcu1sfe_pkg::ModeQueue, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeQueue, bcu1sfe_pkg::ByteIdle, 1'b1,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeQueue, 8'h12, 1'b1, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h01, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0, FailEndSync));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h41, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h99, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'h80, 1'b0, bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
  endtask

  task automatic test_full_frame();
    gaps_on = 1'b0;
    queue_frame(MaxFrame, 2);
    drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                         bcu1sfe_pkg::FailNone));
    drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                         bcu1sfe_pkg::FailNone));
    answer_frame_bytes(1'b1);
  endtask

  task automatic test_random_traffic();
    int pick;
    int len;
    int extra;
    logic [7:0] reply;
    logic [1:0] fail_code;
    while (items_accepted < TargetItems) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 85 && link_phase != LinkIdle) begin
        drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 2'($urandom_range(1, 3))));
      end
      if (pick < 40) begin
        if (!frame_pending) begin
          len = ($urandom_range(0, 9) == 0) ? MaxFrame : $urandom_range(1, 6);
          extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
          queue_frame(len, extra);
        end
        if ($urandom_range(0, 4) == 0) begin
          drive_item(link_item(bcu1sfe_pkg::ModeQueue, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
        end
        drive_item(link_item(bcu1sfe_pkg::ModePoll, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
        fail_code = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) :
                    bcu1sfe_pkg::FailNone;
        drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle,
                             1'($urandom_range(0, 1)), fail_code));
        answer_frame_bytes(1'b0);
      end else if (pick < 75) begin
        drive_item(link_item(bcu1sfe_pkg::ModePoll, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
        reply[7:5] = 3'($urandom_range(0, 7));
        reply[4:0] = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) :
                     5'($urandom_range(0, 5));
        if (reply == bcu1sfe_pkg::ByteIdle) reply = 8'h7f;
        drive_item(link_item(bcu1sfe_pkg::ModeDone, reply, 1'($urandom_range(0, 1)),
                             bcu1sfe_pkg::FailNone));
        while (link_phase == LinkRecv) begin
          fail_code = ($urandom_range(0, 24) == 0) ? 2'($urandom_range(1, 3)) :
                      bcu1sfe_pkg::FailNone;
          drive_item(link_item(bcu1sfe_pkg::ModeDone, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), fail_code));
        end
      end else if (pick < 85) begin
        drive_item(link_item(bcu1sfe_pkg::ModePoll, bcu1sfe_pkg::ByteZero, 1'b0,
                             bcu1sfe_pkg::FailNone));
        drive_item(link_item(bcu1sfe_pkg::ModeDone, bcu1sfe_pkg::ByteIdle, 1'b0,
                             bcu1sfe_pkg::FailNone));
        answer_frame_bytes(1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          drive_item(link_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_style <= $urandom_range(0, 3);
      unique case (stall_style)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= (stall_cycle % 5) < 2;
        default: out_stall_i <= (stall_cycle % 16) >= 12;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    bcu1sfe_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result %h", out_item_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item_o.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_item_o.kind);
          mismatches++;
        end
        if (out_item_o.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", want.tx_byte, out_item_o.tx_byte);
          mismatches++;
        end
        if (out_item_o.rx_byte !== want.rx_byte) begin
          $error("rx_byte: expected %h, actual %h", want.rx_byte, out_item_o.rx_byte);
          mismatches++;
        end
        if (out_item_o.rx_frame_end !== want.rx_frame_end) begin
          $error("rx_frame_end: expected %0d, actual %0d", want.rx_frame_end,
                 out_item_o.rx_frame_end);
          mismatches++;
        end
        if (out_item_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code,
                 out_item_o.error_code);
          mismatches++;
        end
        if (out_item_o.dropped !== want.dropped) begin
          $error("dropped: expected %0d, actual %0d", want.dropped, out_item_o.dropped);
          mismatches++;
        end
        if (out_item_o.last_result !== want.last_result) begin
          $error("last_result: expected %0d, actual %0d", want.last_result,
                 out_item_o.last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_link();
    test_receive_paths();
    test_send_paths();
    test_full_frame();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bcu1sfe_pkg.sv
sv/bcu1sfe_front.sv
sv/bcu1sfe_queue.sv
sv/bcu1sfe_back.sv
sv/bcu1_serial_frame_exchange_unit.sv
test/bcu1_serial_frame_exchange_unit_tb.sv
